// ----- rtl/midi_cc_route_table_top_macros.svh -----
`ifndef MIDI_CC_ROUTE_TABLE_TOP_MACROS_SVH
`define MIDI_CC_ROUTE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MCCRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mccrt: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MCCRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mccrt: next-cycle check failed");

`endif

// ----- rtl/mccrt_pkg.sv -----
`default_nettype none

package mccrt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ENTRIES_DEF = 8;
    localparam int KEY_W       = 11;
    localparam int TGT_W       = 8;

    // Upper nibble of a control change status byte
    localparam logic [3:0] CC_STATUS_HI = 4'hB;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_ROUTE  = 1'b1;

    typedef enum logic [2:0] {
        RES_INSERTED  = 3'd0,
        RES_NO_SLOT   = 3'd1,
        RES_NO_ENTRY  = 3'd2,
        RES_TARGET    = 3'd3,
        RES_MISS      = 3'd4,
        RES_HIT_EMPTY = 3'd5,
        RES_NOT_CC    = 3'd6
    } res_code_t;

    typedef struct packed {
        logic       op;
        logic [3:0] map_channel;
        logic [6:0] map_controller;
        logic [7:0] target;
        logic [7:0] msg_status;
        logic [6:0] msg_data1;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] dest;
        logic       last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SLOT_RD,
        S_SLOT_CMP,
        S_NOMATCH,
        S_USE,
        S_ENT_RD,
        S_ENT_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        logic      clr_idx;
        logic      inc_idx;
        logic      take_match;
        logic      take_claim;
        logic      commit;
        logic      clr_n;
        logic      inc_n;
        logic      emit;
        logic      emit_last;
        logic      emit_dest;
        res_code_t code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic lookup;
        logic not_cc;
        logic count_zero;
        logic table_full;
        logic last_slot;
        logic key_match;
        logic entry_full;
        logic fill_zero;
        logic last_entry;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/mccrt_ctrl.sv -----
`default_nettype none

module mccrt_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  mccrt_pkg::sts_t   sts,
    output logic              busy,
    output mccrt_pkg::cmd_t   cmd
);

    mccrt_pkg::state_t state_reg;
    mccrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mccrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mccrt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = mccrt_pkg::S_DISPATCH;
                end
            end
            mccrt_pkg::S_DISPATCH:
            begin
                if (sts.lookup && sts.not_cc)
                begin
                    state_next = mccrt_pkg::S_IDLE;
                end
                else if (sts.count_zero)
                begin
                    state_next = mccrt_pkg::S_NOMATCH;
                end
                else
                begin
                    state_next = mccrt_pkg::S_SLOT_RD;
                end
            end
            mccrt_pkg::S_SLOT_RD:
            begin
                state_next = mccrt_pkg::S_SLOT_CMP;
            end
            mccrt_pkg::S_SLOT_CMP:
            begin
                if (sts.key_match)
                begin
                    state_next = mccrt_pkg::S_USE;
                end
                else if (sts.last_slot)
                begin
                    state_next = mccrt_pkg::S_NOMATCH;
                end
                else
                begin
                    state_next = mccrt_pkg::S_SLOT_RD;
                end
            end
            mccrt_pkg::S_NOMATCH:
            begin
                if (sts.lookup || sts.table_full)
                begin
                    state_next = mccrt_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mccrt_pkg::S_USE;
                end
            end
            mccrt_pkg::S_USE:
            begin
                if (!sts.lookup || sts.fill_zero)
                begin
                    state_next = mccrt_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mccrt_pkg::S_ENT_RD;
                end
            end
            mccrt_pkg::S_ENT_RD:
            begin
                state_next = mccrt_pkg::S_ENT_EMIT;
            end
            mccrt_pkg::S_ENT_EMIT:
            begin
                if (sts.last_entry)
                begin
                    state_next = mccrt_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mccrt_pkg::S_ENT_RD;
                end
            end
            default:
            begin
                state_next = mccrt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.code = mccrt_pkg::RES_INSERTED;
        busy     = (state_reg != mccrt_pkg::S_IDLE);
        case (state_reg)
            mccrt_pkg::S_IDLE:
            begin
                cmd.capture = start;
            end
            mccrt_pkg::S_DISPATCH:
            begin
                cmd.clr_idx = 1'b1;
                if (sts.lookup && sts.not_cc)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.code      = mccrt_pkg::RES_NOT_CC;
                end
            end
            mccrt_pkg::S_SLOT_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.take_match = 1'b1;
                end
                else if (!sts.last_slot)
                begin
                    cmd.inc_idx = 1'b1;
                end
            end
            mccrt_pkg::S_NOMATCH:
            begin
                if (sts.lookup)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.code      = mccrt_pkg::RES_MISS;
                end
                else if (sts.table_full)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.code      = mccrt_pkg::RES_NO_SLOT;
                end
                else
                begin
                    cmd.take_claim = 1'b1;
                end
            end
            mccrt_pkg::S_USE:
            begin
                cmd.clr_n = 1'b1;
                if (!sts.lookup)
                begin
                    cmd.commit    = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.code      = sts.entry_full ? mccrt_pkg::RES_NO_ENTRY
                                                   : mccrt_pkg::RES_INSERTED;
                end
                else if (sts.fill_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.code      = mccrt_pkg::RES_HIT_EMPTY;
                end
            end
            mccrt_pkg::S_ENT_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_dest = 1'b1;
                cmd.emit_last = sts.last_entry;
                cmd.code      = mccrt_pkg::RES_TARGET;
                cmd.inc_n     = !sts.last_entry;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/mccrt_dp.sv -----
`default_nettype none

module mccrt_dp #(
    parameter int SLOTS   = mccrt_pkg::SLOTS_DEF,
    parameter int ENTRIES = mccrt_pkg::ENTRIES_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  mccrt_pkg::req_t   req,
    input  mccrt_pkg::cmd_t   cmd,
    output mccrt_pkg::sts_t   sts,
    output logic              strobe,
    output mccrt_pkg::res_t   result
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int FW    = $clog2(ENTRIES + 1);
    localparam int DEPTH = SLOTS * ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = mccrt_pkg::KEY_W;
    localparam int TW    = mccrt_pkg::TGT_W;

    // Slot store: slots fill in order and are never freed, so a count marks the used ones.
    logic [KW-1:0] slot_key_mem  [SLOTS];
    logic [FW-1:0] slot_fill_mem [SLOTS];
    logic [TW-1:0] ent_mem       [DEPTH];

    logic [KW-1:0] key_rd_reg;
    logic [FW-1:0] fill_rd_reg;
    logic [TW-1:0] ent_rd_reg;

    logic          op_reg,      op_next;
    logic          not_cc_reg,  not_cc_next;
    logic [KW-1:0] key_reg,     key_next;
    logic [TW-1:0] tgt_reg,     tgt_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [SW-1:0] idx_reg,     idx_next;
    logic [SW-1:0] slot_reg,    slot_next;
    logic [AW-1:0] base_reg,    base_next;
    logic [FW-1:0] fill_reg,    fill_next;
    logic [FW-1:0] n_reg,       n_next;
    logic          claim_reg,   claim_next;
    logic          strobe_reg,  strobe_next;
    mccrt_pkg::res_t res_reg,   res_next;

    logic [FW-1:0] fill_new;
    logic [AW-1:0] ent_wr_addr;
    logic [AW-1:0] ent_rd_addr;
    logic          entry_full;

    assign entry_full  = (fill_reg == FW'(ENTRIES));
    assign fill_new    = entry_full ? fill_reg : fill_reg + FW'(1);
    assign ent_wr_addr = base_reg + AW'(fill_reg);
    assign ent_rd_addr = base_reg + AW'(n_reg);

    always_comb
    begin
        sts.lookup     = (op_reg == mccrt_pkg::OP_ROUTE);
        sts.not_cc     = not_cc_reg;
        sts.count_zero = (count_reg == '0);
        sts.table_full = (count_reg == CW'(SLOTS));
        sts.last_slot  = ((CW'(idx_reg) + CW'(1)) == count_reg);
        sts.key_match  = (key_rd_reg == key_reg);
        sts.entry_full = entry_full;
        sts.fill_zero  = (fill_reg == '0);
        sts.last_entry = ((n_reg + FW'(1)) == fill_reg);
    end

    always_comb
    begin
        op_next     = op_reg;
        not_cc_next = not_cc_reg;
        key_next    = key_reg;
        tgt_next    = tgt_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        base_next   = base_reg;
        fill_next   = fill_reg;
        n_next      = n_reg;
        claim_next  = claim_reg;
        strobe_next = cmd.emit;
        res_next    = res_reg;

        if (cmd.capture)
        begin
            op_next     = req.op;
            not_cc_next = (req.msg_status[7:4] != mccrt_pkg::CC_STATUS_HI);
            key_next    = (req.op == mccrt_pkg::OP_ROUTE)
                        ? {req.msg_status[3:0], req.msg_data1}
                        : {req.map_channel, req.map_controller};
            tgt_next    = req.target;
        end
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        if (cmd.inc_idx)
        begin
            idx_next = idx_reg + SW'(1);
        end
        if (cmd.take_match)
        begin
            slot_next  = idx_reg;
            base_next  = AW'(idx_reg * ENTRIES);
            fill_next  = fill_rd_reg;
            claim_next = 1'b0;
        end
        if (cmd.take_claim)
        begin
            slot_next  = count_reg[SW-1:0];
            base_next  = AW'(count_reg * ENTRIES);
            fill_next  = '0;
            claim_next = 1'b1;
        end
        if (cmd.commit && claim_reg)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.clr_n)
        begin
            n_next = '0;
        end
        if (cmd.inc_n)
        begin
            n_next = n_reg + FW'(1);
        end
        if (cmd.emit)
        begin
            res_next.status = 3'(cmd.code);
            res_next.dest   = cmd.emit_dest ? ent_rd_reg : '0;
            res_next.last   = cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        not_cc_reg <= not_cc_next;
        key_reg    <= key_next;
        tgt_reg    <= tgt_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        base_reg   <= base_next;
        fill_reg   <= fill_next;
        n_reg      <= n_next;
        claim_reg  <= claim_next;
        res_reg    <= res_next;
    end

    // Slot store: write on commit, read at the scan index every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_key_mem[slot_reg]  <= key_reg;
            slot_fill_mem[slot_reg] <= fill_new;
        end
        key_rd_reg  <= slot_key_mem[idx_reg];
        fill_rd_reg <= slot_fill_mem[idx_reg];
    end

    // Target store: entries fill in order, so the slot's fill count marks the used ones
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !entry_full)
        begin
            ent_mem[ent_wr_addr] <= tgt_reg;
        end
        ent_rd_reg <= ent_mem[ent_rd_addr];
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ----- rtl/midi_cc_route_table_top.sv -----
// MIDI control-change routing table. Raise start with a request on req while
// busy is low; the request is taken at that clock edge. op 0 inserts a target
// under a channel:controller key (one result: inserted, no slot, or no entry),
// op 1 routes a raw MIDI message (one result for a non control change, a miss
// or an empty hit, otherwise one result per mapped target in insertion order,
// the final one flagged by last). Results appear on result for exactly one
// cycle each, qualified by strobe; there is no back-pressure, so capture every
// strobe. Slot keys sit in a memory with a registered read, scanned from slot 0:
// each used slot is read (S_SLOT_RD), then compared (S_SLOT_CMP). An insert
// stops at its key's slot, or past all used slots claims the next (S_NOMATCH).
// A route takes the same scan, then reads each target from the target memory
// (S_ENT_RD, S_ENT_EMIT). A non control change is answered from S_DISPATCH
// with no scan. busy falls in the cycle the final strobe is shown, so the next
// request can follow at once. The table clears by reset alone: no clearing
// pass is needed, since a count tracks used slots and fill counts used entries.
`default_nettype none

`include "midi_cc_route_table_top_macros.svh"

module midi_cc_route_table_top #(
    parameter int SLOTS   = mccrt_pkg::SLOTS_DEF,
    parameter int ENTRIES = mccrt_pkg::ENTRIES_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  mccrt_pkg::req_t   req,
    output logic              busy,
    output logic              strobe,
    output mccrt_pkg::res_t   result
);

    mccrt_pkg::cmd_t cmd;
    mccrt_pkg::sts_t sts;

    // Strobed result that is not a routed target
    logic non_target;

    // Sequence the scan, claim, commit and target read-out
    mccrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Hold the request, the slot and target stores, and the result register
    mccrt_dp #(
        .SLOTS   (SLOTS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .sts    (sts),
        .strobe (strobe),
        .result (result)
    );

    assign non_target = strobe && (result.status != mccrt_pkg::RES_TARGET);

    // Every accepted request makes the block busy in the following cycle
    `MCCRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // The final result of a request releases the block in the same cycle
    `MCCRT_ASSERT_SAME(a_last_idle, strobe && result.last, !busy)
    // Only target results may be followed by more results
    `MCCRT_ASSERT_SAME(a_single_last, non_target, result.last)
    // Non-target results carry no destination
    `MCCRT_ASSERT_SAME(a_dest_zero, non_target, result.dest == 8'd0)

endmodule

`default_nettype wire

// ----- tb/tb_midi_cc_route_table_top.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the MIDI control-change routing table.
//
// Flow: a short table of hand-picked requests runs first (empty-table lookups,
// non control-change status bytes, duplicate targets, filling one key's target
// list to the brim and overflowing it), then a long random phase that works a
// small pool of keys so the slots fill up and lookups mostly hit.
//
// Every accepted request goes through a behavioral copy of the table kept in
// this bench, and its results are queued. The monitor pops the oldest queued
// result on each strobe and compares status, dest and last.
module tb_midi_cc_route_table_top;

    localparam int SLOT_COUNT  = mccrt_pkg::SLOTS_DEF;
    localparam int ENTRY_COUNT = mccrt_pkg::ENTRIES_DEF;
    localparam int KEY_BITS    = mccrt_pkg::KEY_W;
    localparam int TGT_BITS    = mccrt_pkg::TGT_W;
    localparam int KEY_POOL    = 22;
    localparam int RANDOM_REQS = 400;
    // No accept and no strobe for this long means the block has hung
    localparam int STALL_LIMIT = 3000;
    // Covers the slowest lookup: full slot scan plus eight target reads
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        mccrt_pkg::req_t      r;
        logic                 typed;   // expectation typed in below rather than predicted
        mccrt_pkg::res_code_t code;
    } step_row_t;

    logic            clk;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    mccrt_pkg::req_t req   = '0;
    logic            busy;
    logic            strobe;
    mccrt_pkg::res_t result;

    // Shadow of the routing table
    logic                slot_taken [SLOT_COUNT];
    logic [KEY_BITS-1:0] slot_tag   [SLOT_COUNT];
    logic                ent_taken  [SLOT_COUNT * ENTRY_COUNT];
    logic [TGT_BITS-1:0] ent_dest   [SLOT_COUNT * ENTRY_COUNT];

    mccrt_pkg::res_t outcome_q[$];      // results of the request just accepted
    mccrt_pkg::res_t pending_res_q[$];  // results still owed by the block, oldest first

    int fault_count   = 0;
    int results_seen  = 0;
    int inserts_sent  = 0;
    int routes_sent   = 0;
    int quiet_cycles  = 0;
    int seen_by_code[8];

    midi_cc_route_table_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Lowest slot holding the key, or -1
    function automatic int find_tag(input logic [KEY_BITS-1:0] key);
        int hit;
        hit = -1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (slot_taken[i] && slot_tag[i] == key)
                hit = i;
        end
        return hit;
    endfunction

    // Apply one request to the shadow table and leave its results in outcome_q
    function automatic void route_table_outcome(input mccrt_pkg::req_t r);
        logic [KEY_BITS-1:0]  key;
        int                   s;
        int                   hits;
        logic                 placed;
        mccrt_pkg::res_code_t code;
        mccrt_pkg::res_t      res;
        outcome_q.delete();
        if (r.op == mccrt_pkg::OP_INSERT)
        begin
            key = {r.map_channel, r.map_controller};
            s = find_tag(key);
            code = mccrt_pkg::RES_NO_ENTRY;
            if (s < 0)
            begin
                // Claim the lowest free slot
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                begin
                    if (!slot_taken[i])
                        s = i;
                end
                if (s < 0)
                    code = mccrt_pkg::RES_NO_SLOT;
                else
                begin
                    slot_taken[s] = 1'b1;
                    slot_tag[s]   = key;
                end
            end
            if (s >= 0)
            begin
                placed = 1'b0;
                for (int n = 0; n < ENTRY_COUNT; n++)
                begin
                    if (!placed && !ent_taken[s * ENTRY_COUNT + n])
                    begin
                        ent_taken[s * ENTRY_COUNT + n] = 1'b1;
                        ent_dest[s * ENTRY_COUNT + n]  = r.target;
                        placed = 1'b1;
                        code   = mccrt_pkg::RES_INSERTED;
                    end
                end
            end
            res = '{status: code, dest: '0, last: 1'b1};
            outcome_q.push_back(res);
        end
        else if (r.msg_status[7:4] != mccrt_pkg::CC_STATUS_HI)
        begin
            res = '{status: mccrt_pkg::RES_NOT_CC, dest: '0, last: 1'b1};
            outcome_q.push_back(res);
        end
        else
        begin
            key = {r.msg_status[3:0], r.msg_data1};
            s = find_tag(key);
            if (s < 0)
            begin
                res = '{status: mccrt_pkg::RES_MISS, dest: '0, last: 1'b1};
                outcome_q.push_back(res);
            end
            else
            begin
                // Targets run up to the first unused entry
                hits = 0;
                placed = 1'b1;
                for (int n = 0; n < ENTRY_COUNT; n++)
                begin
                    if (placed && ent_taken[s * ENTRY_COUNT + n])
                        hits++;
                    else
                        placed = 1'b0;
                end
                if (hits == 0)
                begin
                    res = '{status: mccrt_pkg::RES_HIT_EMPTY, dest: '0, last: 1'b1};
                    outcome_q.push_back(res);
                end
                for (int n = 0; n < hits; n++)
                begin
                    res = '{status: mccrt_pkg::RES_TARGET,
                            dest: ent_dest[s * ENTRY_COUNT + n],
                            last: (n == hits - 1)};
                    outcome_q.push_back(res);
                end
            end
        end
    endfunction

    function automatic mccrt_pkg::req_t mk_ins(input logic [3:0] ch, input logic [6:0] ctl,
                                               input logic [7:0] tgt);
        mccrt_pkg::req_t r;
        r = '0;
        r.op             = mccrt_pkg::OP_INSERT;
        r.map_channel    = ch;
        r.map_controller = ctl;
        r.target         = tgt;
        return r;
    endfunction

    function automatic mccrt_pkg::req_t mk_msg(input logic [7:0] st, input logic [6:0] d1);
        mccrt_pkg::req_t r;
        r = '0;
        r.op         = mccrt_pkg::OP_ROUTE;
        r.msg_status = st;
        r.msg_data1  = d1;
        return r;
    endfunction

    // Present one request until taken, then queue its results.
    // Drop start in about a quarter of the cycles unless told to stay busy.
    task automatic issue(input mccrt_pkg::req_t r, input logic typed,
                         input mccrt_pkg::res_code_t code, input logic no_gaps);
        mccrt_pkg::res_t want;
        logic            go;
        logic            taken;
        taken = 1'b0;
        while (!taken)
        begin
            go = no_gaps || ($urandom_range(99) >= 26);
            start <= go;
            req   <= r;
            @(posedge clk);
            taken = go && (busy === 1'b0);
        end
        route_table_outcome(r);
        if (typed)
        begin
            want = '{status: code, dest: '0, last: 1'b1};
            pending_res_q.push_back(want);
        end
        else
        begin
            foreach (outcome_q[k])
                pending_res_q.push_back(outcome_q[k]);
        end
        if (r.op == mccrt_pkg::OP_INSERT)
            inserts_sent++;
        else
            routes_sent++;
    endtask

    // Drop start and hold off until every owed result has arrived
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_res_q.size() != 0)
            @(posedge clk);
    endtask

    // Check each strobed result against the oldest expectation, and watch
    // for a block that stops making progress.
    always @(posedge clk)
    begin
        mccrt_pkg::res_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                results_seen++;
                seen_by_code[result.status]++;
                if (pending_res_q.size() == 0)
                begin
                    fault_count++;
                    if (fault_count < 40)
                        $display("%0t: unexpected result: expected none, %s %0d dest %0d last %0d",
                                 $time, "got status", result.status, result.dest,
                                 result.last);
                end
                else
                begin
                    want = pending_res_q.pop_front();
                    if (result.status !== want.status || result.dest !== want.dest ||
                        result.last !== want.last)
                    begin
                        fault_count++;
                        if (fault_count < 40)
                            $display("%0t: result mismatch: expected %s %0d dest %0d last %0d,",
                                     $time, "status", want.status, want.dest, want.last,
                                     " got status %0d dest %0d last %0d",
                                     result.status, result.dest, result.last);
                    end
                end
            end
            if (strobe || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request taken and no result for %0d cycles, %0d results owed",
                         $time, STALL_LIMIT, pending_res_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        step_row_t           plan[$];
        logic [KEY_BITS-1:0] key_pool[KEY_POOL];
        logic [63:0]         noise;
        logic [31:0]         word;
        logic [KEY_BITS-1:0] pick;
        mccrt_pkg::req_t     r;
        int                  roll;

        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_taken[i] = 1'b0;
            slot_tag[i]   = '0;
        end
        for (int i = 0; i < SLOT_COUNT * ENTRY_COUNT; i++)
        begin
            ent_taken[i] = 1'b0;
            ent_dest[i]  = '0;
        end
        foreach (seen_by_code[i])
            seen_by_code[i] = 0;

        // Empty table: a control change misses, anything else is not one
        plan.push_back('{mk_msg(8'hB0, 7'h00), 1'b1, mccrt_pkg::RES_MISS});
        plan.push_back('{mk_msg(8'h00, 7'h7F), 1'b1, mccrt_pkg::RES_NOT_CC});
        plan.push_back('{mk_msg(8'hFF, 7'h7F), 1'b1, mccrt_pkg::RES_NOT_CC});
        plan.push_back('{mk_msg(8'hAF, 7'h00), 1'b1, mccrt_pkg::RES_NOT_CC});
        plan.push_back('{mk_msg(8'hC0, 7'h00), 1'b1, mccrt_pkg::RES_NOT_CC});
        // Top key, extreme targets, and a duplicate target stored twice
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'hFF), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'h00), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'hFF), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_msg(8'hBF, 7'h7F), 1'b0, mccrt_pkg::RES_TARGET});
        // Neighbors of a stored key must not match
        plan.push_back('{mk_msg(8'hBF, 7'h7E), 1'b1, mccrt_pkg::RES_MISS});
        plan.push_back('{mk_msg(8'hAF, 7'h7F), 1'b1, mccrt_pkg::RES_NOT_CC});
        plan.push_back('{mk_ins(4'h0, 7'h00, 8'hA5), 1'b1, mccrt_pkg::RES_INSERTED});
        // Fill the top key's target list, then overflow it
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'h5A), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'h01), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'h80), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'h7F), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'hFE), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_ins(4'hF, 7'h7F, 8'h33), 1'b1, mccrt_pkg::RES_NO_ENTRY});
        plan.push_back('{mk_msg(8'hBF, 7'h7F), 1'b0, mccrt_pkg::RES_TARGET});
        plan.push_back('{mk_msg(8'hB0, 7'h00), 1'b0, mccrt_pkg::RES_TARGET});
        plan.push_back('{mk_msg(8'hB0, 7'h7F), 1'b1, mccrt_pkg::RES_MISS});
        plan.push_back('{mk_msg(8'hBF, 7'h00), 1'b1, mccrt_pkg::RES_MISS});
        plan.push_back('{mk_ins(4'h8, 7'h40, 8'hAA), 1'b1, mccrt_pkg::RES_INSERTED});
        plan.push_back('{mk_msg(8'hB8, 7'h40), 1'b0, mccrt_pkg::RES_TARGET});

        // Hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue(plan[i].r, plan[i].typed, plan[i].code, 1'b0);
        drain_results();

        // A few keys more than there are slots, so the table runs out of room
        foreach (key_pool[i])
        begin
            word        = $urandom;
            key_pool[i] = word[KEY_BITS-1:0];
        end

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            noise = {$urandom, $urandom};
            r     = noise[$bits(mccrt_pkg::req_t)-1:0];
            pick  = key_pool[$urandom_range(KEY_POOL - 1)];
            roll  = $urandom_range(99);
            if (roll < 46)
            begin
                r.op = mccrt_pkg::OP_INSERT;
                {r.map_channel, r.map_controller} = pick;
            end
            else if (roll < 50)
                r.op = mccrt_pkg::OP_INSERT;
            else if (roll < 88)
            begin
                r.op         = mccrt_pkg::OP_ROUTE;
                r.msg_status = {mccrt_pkg::CC_STATUS_HI, pick[KEY_BITS-1:7]};
                r.msg_data1  = pick[6:0];
            end
            else if (roll < 94)
            begin
                r.op                = mccrt_pkg::OP_ROUTE;
                r.msg_status[7:4]   = mccrt_pkg::CC_STATUS_HI;
            end
            else
                r.op = mccrt_pkg::OP_ROUTE;

            // Keep the middle stretch back to back; pause once to drain
            issue(r, 1'b0, mccrt_pkg::RES_TARGET, (i >= 120 && i < 240));
            if (i == 300)
                drain_results();
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_res_q.size() != 0)
            @(posedge clk);
        // Let any stray strobe show up before closing out
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d inserts and %0d routes, %0d results checked",
                 inserts_sent, routes_sent, results_seen);
        $display("outcomes: inserted %0d, no slot %0d, no entry %0d, target %0d, %s %0d, %s %0d",
                 seen_by_code[mccrt_pkg::RES_INSERTED], seen_by_code[mccrt_pkg::RES_NO_SLOT],
                 seen_by_code[mccrt_pkg::RES_NO_ENTRY], seen_by_code[mccrt_pkg::RES_TARGET],
                 "miss", seen_by_code[mccrt_pkg::RES_MISS],
                 "not cc", seen_by_code[mccrt_pkg::RES_NOT_CC]);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
